@@ hw/rtl/cte_pkg.sv @@
`timescale 1ns / 1ps

package cte_pkg;

   // request function codes
   typedef enum logic [2:0] {
      FUNC_TICK   = 3'd0,
      FUNC_MODE   = 3'd1,
      FUNC_SELECT = 3'd2,
      FUNC_UP     = 3'd3,
      FUNC_DOWN   = 3'd4,
      FUNC_SAMPLE = 3'd5
   } func_type;

   // edited field indexes
   localparam logic [2:0] FIELD_YEAR   = 3'd0;
   localparam logic [2:0] FIELD_MONTH  = 3'd1;
   localparam logic [2:0] FIELD_DAY    = 3'd2;
   localparam logic [2:0] FIELD_HOUR   = 3'd3;
   localparam logic [2:0] FIELD_MINUTE = 3'd4;
   localparam logic [2:0] FIELD_SECOND = 3'd5;

   localparam logic [15:0] BLINK_PERIOD_RESET = 16'd500;

   // the six calendar fields at their port widths
   typedef struct packed {
      logic [6:0] year;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } time_type;

endpackage

@@ hw/rtl/calendar_time_set_editor.sv @@
`timescale 1ns / 1ps

// Calendar time set editor.
// Request channel (req_valid/req_stall): one function code per request plus
// an RTC reading that only a sample request uses. Response channel
// (rsp_valid/rsp_stall): one response per request with mode, edited field,
// blank flag, the six calendar fields and the write-back flag.
// A taken request sits in the input register; the state update and the
// response register load happen together when it advances, which waits
// while the response register holds a stalled response.
// One request per cycle is taken when the response side keeps up; the input
// register and the response register each hold one request, and the edit
// logic between them is combinational.
// When rsp_stall is high the response holds and req_stall rises once the
// input register is full. csr_ready is always high; the user must write the
// blink period only while the block is idle; the block does not enforce it.
// Synchronous reset clears both registers' valid flags, the fields, mode,
// selection, blink phase and tick count, and sets the blink period to 500.

module calendar_time_set_editor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_func,
   input  logic [6:0]  req_sample_year,
   input  logic [3:0]  req_sample_month,
   input  logic [4:0]  req_sample_day,
   input  logic [4:0]  req_sample_hour,
   input  logic [5:0]  req_sample_minute,
   input  logic [5:0]  req_sample_second,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_set_mode,
   output logic [2:0]  rsp_selected_field,
   output logic        rsp_blank_selected,
   output logic [6:0]  rsp_out_year,
   output logic [3:0]  rsp_out_month,
   output logic [4:0]  rsp_out_day,
   output logic [4:0]  rsp_out_hour,
   output logic [5:0]  rsp_out_minute,
   output logic [5:0]  rsp_out_second,
   output logic        rsp_write_rtc,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_blink_period_ticks
);

   logic              req_valid_ff;
   logic [2:0]        req_func_ff;
   cte_pkg::time_type sample_ff;

   cte_pkg::time_type fields_ff, fields_in;
   logic              mode_ff, mode_in;
   logic [2:0]        sel_ff, sel_in;
   logic              phase_ff, phase_in;
   logic [15:0]       tick_ff, tick_in;
   logic [15:0]       period_ff;

   logic              rsp_valid_ff;
   logic              rsp_write_ff, rsp_write_in;
   cte_pkg::time_type rsp_fields_ff;
   logic              rsp_mode_ff;
   logic [2:0]        rsp_sel_ff;
   logic              rsp_blank_ff;

   logic              req_take;
   logic              out_free;
   logic              advance;
   logic [15:0]       tick_inc;
   cte_pkg::time_type fields_edit;

   // handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = req_valid_ff && out_free;
   assign req_stall = req_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   cte_edit u_edit (
      .fields_cur (fields_ff),
      .sel        (sel_ff),
      .down       (req_func_ff == cte_pkg::FUNC_DOWN),
      .fields_new (fields_edit)
   );

   assign tick_inc = tick_ff + 16'd1;

   // next state for the request in the input register
   always_comb begin
      fields_in    = fields_ff;
      mode_in      = mode_ff;
      sel_in       = sel_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      rsp_write_in = 1'b0;
      case (req_func_ff)
         cte_pkg::FUNC_TICK: begin
            if (tick_inc >= period_ff) begin
               tick_in  = 16'd0;
               phase_in = !phase_ff;
            end else begin
               tick_in = tick_inc;
            end
         end
         cte_pkg::FUNC_MODE: begin
            mode_in      = !mode_ff;
            rsp_write_in = mode_ff;
         end
         cte_pkg::FUNC_SELECT: begin
            if (mode_ff) begin
               sel_in = (sel_ff == cte_pkg::FIELD_SECOND) ? cte_pkg::FIELD_YEAR
                                                          : sel_ff + 3'd1;
            end
         end
         cte_pkg::FUNC_UP,
         cte_pkg::FUNC_DOWN: begin
            if (mode_ff) begin
               fields_in = fields_edit;
            end
         end
         cte_pkg::FUNC_SAMPLE: begin
            if (!mode_ff) begin
               fields_in = sample_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_take) begin
         req_valid_ff <= 1'b1;
      end else if (advance) begin
         req_valid_ff <= 1'b0;
      end
      if (req_take) begin
         req_func_ff      <= req_func;
         sample_ff.year   <= req_sample_year;
         sample_ff.month  <= req_sample_month;
         sample_ff.day    <= req_sample_day;
         sample_ff.hour   <= req_sample_hour;
         sample_ff.minute <= req_sample_minute;
         sample_ff.second <= req_sample_second;
      end
   end

   // editor state and blink period
   always_ff @(posedge clock) begin
      if (reset) begin
         fields_ff <= '0;
         mode_ff   <= 1'b0;
         sel_ff    <= cte_pkg::FIELD_YEAR;
         phase_ff  <= 1'b0;
         tick_ff   <= 16'd0;
         period_ff <= cte_pkg::BLINK_PERIOD_RESET;
      end else begin
         if (advance) begin
            fields_ff <= fields_in;
            mode_ff   <= mode_in;
            sel_ff    <= sel_in;
            phase_ff  <= phase_in;
            tick_ff   <= tick_in;
         end
         if (csr_valid && csr_ready) begin
            period_ff <= csr_blink_period_ticks;
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_fields_ff <= fields_in;
         rsp_mode_ff   <= mode_in;
         rsp_sel_ff    <= sel_in;
         rsp_blank_ff  <= mode_in && phase_in;
         rsp_write_ff  <= rsp_write_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_set_mode       = rsp_mode_ff;
   assign rsp_selected_field = rsp_sel_ff;
   assign rsp_blank_selected = rsp_blank_ff;
   assign rsp_out_year       = rsp_fields_ff.year;
   assign rsp_out_month      = rsp_fields_ff.month;
   assign rsp_out_day        = rsp_fields_ff.day;
   assign rsp_out_hour       = rsp_fields_ff.hour;
   assign rsp_out_minute     = rsp_fields_ff.minute;
   assign rsp_out_second     = rsp_fields_ff.second;
   assign rsp_write_rtc      = rsp_write_ff;

endmodule

@@ hw/rtl/cte_edit.sv @@
`timescale 1ns / 1ps

module cte_edit (
   input  cte_pkg::time_type fields_cur,
   input  logic [2:0]        sel,
   input  logic              down,
   output cte_pkg::time_type fields_new
);

   logic signed [8:0] delta;
   logic signed [8:0] v_year;
   logic signed [8:0] v_month;
   logic signed [8:0] v_day;
   logic signed [8:0] v_hour;
   logic signed [8:0] v_minute;
   logic signed [8:0] v_second;
   logic [6:0]        w_year;
   logic [6:0]        w_month;
   logic [6:0]        w_day;
   logic [6:0]        w_hour;
   logic [6:0]        w_minute;
   logic [6:0]        w_second;
   logic [4:0]        day_max;

   // below the range gives the top, above gives the bottom
   function automatic logic [6:0] wrap_val(input logic signed [8:0] v,
                                           input logic signed [8:0] lo,
                                           input logic signed [8:0] hi);
      logic [6:0] r;
      if (v < lo) begin
         r = hi[6:0];
      end else if (v > hi) begin
         r = lo[6:0];
      end else begin
         r = v[6:0];
      end
      return r;
   endfunction

   function automatic logic [4:0] days_in_month(input logic [3:0] month,
                                                input logic [1:0] year_lsb);
      logic [4:0] d;
      case (month)
         4'd2:    d = (year_lsb == 2'd0) ? 5'd29 : 5'd28;
         4'd4,
         4'd6,
         4'd9,
         4'd11:   d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

   assign delta = down ? -9'sd1 : 9'sd1;

   // step the selected field by one
   assign v_year   = $signed({2'b00, fields_cur.year})
                     + ((sel == cte_pkg::FIELD_YEAR) ? delta : 9'sd0);
   assign v_month  = $signed({5'b00000, fields_cur.month})
                     + ((sel == cte_pkg::FIELD_MONTH) ? delta : 9'sd0);
   assign v_day    = $signed({4'b0000, fields_cur.day})
                     + ((sel == cte_pkg::FIELD_DAY) ? delta : 9'sd0);
   assign v_hour   = $signed({4'b0000, fields_cur.hour})
                     + ((sel == cte_pkg::FIELD_HOUR) ? delta : 9'sd0);
   assign v_minute = $signed({3'b000, fields_cur.minute})
                     + ((sel == cte_pkg::FIELD_MINUTE) ? delta : 9'sd0);
   assign v_second = $signed({3'b000, fields_cur.second})
                     + ((sel == cte_pkg::FIELD_SECOND) ? delta : 9'sd0);

   // wrap every field, day limit after month and year
   assign w_year   = wrap_val(v_year, 9'sd0, 9'sd99);
   assign w_month  = wrap_val(v_month, 9'sd1, 9'sd12);
   assign day_max  = days_in_month(w_month[3:0], w_year[1:0]);
   assign w_day    = wrap_val(v_day, 9'sd1, $signed({4'b0000, day_max}));
   assign w_hour   = wrap_val(v_hour, 9'sd0, 9'sd23);
   assign w_minute = wrap_val(v_minute, 9'sd0, 9'sd59);
   assign w_second = wrap_val(v_second, 9'sd0, 9'sd59);

   assign fields_new.year   = w_year;
   assign fields_new.month  = w_month[3:0];
   assign fields_new.day    = w_day[4:0];
   assign fields_new.hour   = w_hour[4:0];
   assign fields_new.minute = w_minute[5:0];
   assign fields_new.second = w_second[5:0];

endmodule

@@ hw/rtl/cte_checker.sv @@
`timescale 1ns / 1ps

module cte_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_set_mode,
   input logic [2:0]  rsp_selected_field,
   input logic        rsp_blank_selected,
   input logic [6:0]  rsp_out_year,
   input logic        rsp_write_rtc
);

   // a write-back only comes with the return to show mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_write_rtc |-> !rsp_set_mode)
      else $error("write_rtc while still in set mode");

   // blanking only happens in set mode
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blank_selected |-> rsp_set_mode)
      else $error("blank_selected outside set mode");

   // selection stays within the six fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_selected_field <= 3'd5))
      else $error("selected_field out of range");

   // no response straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_year))
      else $error("stalled response changed");

endmodule

bind calendar_time_set_editor cte_checker u_cte_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_set_mode       (rsp_set_mode),
   .rsp_selected_field (rsp_selected_field),
   .rsp_blank_selected (rsp_blank_selected),
   .rsp_out_year       (rsp_out_year),
   .rsp_write_rtc      (rsp_write_rtc)
);
